### rtl/stabilizer_tableau_gate_engine_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stabilizer tableau gate engine
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef STABILIZER_TABLEAU_GATE_ENGINE_UNIT_DEFINES_SVH
`define STABILIZER_TABLEAU_GATE_ENGINE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STGE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stge assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define STGE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stge assertion failed");

`endif

### rtl/stge_pkg.sv
// ----------------------------------------------------------------------------
// Stabilizer tableau gate engine package
// Widths, command and status codes, the row layout and the gate update logic.
// ----------------------------------------------------------------------------
`default_nettype none

package stge_pkg;

  localparam int MAX_QUBITS = 64;
  localparam int QUBIT_W    = $clog2(MAX_QUBITS);
  localparam int COUNT_W    = $clog2(MAX_QUBITS + 1);
  localparam int CMD_W      = 4;
  localparam int STATUS_W   = 2;

  typedef logic [MAX_QUBITS-1:0] obs_vec_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_CX      = 4'd0,
    CMD_CY      = 4'd1,
    CMD_CZ      = 4'd2,
    CMD_SWAP    = 4'd3,
    CMD_H       = 4'd4,
    CMD_H_XY    = 4'd5,
    CMD_H_YZ    = 4'd6,
    CMD_X       = 4'd7,
    CMD_RD_SIGN = 4'd8,
    CMD_RD_ZX   = 4'd9,
    CMD_RD_XZ   = 4'd10,
    CMD_RD_ZZ   = 4'd11
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EQUAL = 2'd2
  } status_t;

  // One stored row holds every column of one qubit across both halves.
  typedef struct packed {
    obs_vec_t xx;
    obs_vec_t xz;
    obs_vec_t zx;
    obs_vec_t zz;
  } row_t;

  typedef struct packed {
    obs_vec_t cx;
    obs_vec_t cz;
    obs_vec_t tx;
    obs_vec_t tz;
    obs_vec_t s;
  } half_t;

  function automatic row_t ident_row(input logic [QUBIT_W-1:0] q);
    row_t     r;
    obs_vec_t one;
    one    = '0;
    one[q] = 1'b1;
    r.xx   = one;
    r.xz   = '0;
    r.zx   = '0;
    r.zz   = one;
    return r;
  endfunction

  // Gate update of one half. For single-qubit gates the caller passes the
  // same columns as both operands, and only tx, tz and s carry the result.
  function automatic half_t gate_half(input cmd_t op, input obs_vec_t a,
                                      input obs_vec_t b, input obs_vec_t c,
                                      input obs_vec_t d, input obs_vec_t s);
    half_t h;
    h.cx = a;
    h.cz = b;
    h.tx = c;
    h.tz = d;
    h.s  = s;
    case (op)
      CMD_CX: begin
        h.s  = s ^ (~(b ^ c) & (a & d));
        h.cz = b ^ d;
        h.tx = c ^ a;
      end
      CMD_CY: begin
        h.s  = s ^ (a & (b ^ c) & (d ^ c));
        h.cz = b ^ c ^ d;
        h.tx = c ^ a;
        h.tz = d ^ a;
      end
      CMD_CZ: begin
        h.s  = s ^ (a & c & (b ^ d));
        h.cz = b ^ c;
        h.tz = d ^ a;
      end
      CMD_SWAP: begin
        h.cx = c;
        h.tx = a;
        h.cz = d;
        h.tz = b;
      end
      CMD_H: begin
        h.tx = d;
        h.tz = c;
        h.s  = s ^ (c & d);
      end
      CMD_H_XY: begin
        h.s  = s ^ (~c & d);
        h.tz = d ^ c;
      end
      CMD_H_YZ: begin
        h.s  = s ^ (~d & c);
        h.tx = c ^ d;
      end
      CMD_X: begin
        h.s  = s ^ d;
      end
      default: begin
        h.s  = s;
      end
    endcase
    return h;
  endfunction

endpackage

`default_nettype wire

### rtl/stge_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/stabilizer_tableau_gate_engine_unit.sv
// ----------------------------------------------------------------------------
// Stabilizer tableau gate engine
// Keeps a transposed stabilizer tableau in a row memory and applies Clifford
// gates to it, or reads single bits, one command at a time.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                              Transfer
//  command   start, cmd, qubit_a, qubit_b, busy   start high and busy low
//  result    done, read_bit, status               done high, one cycle
//  config    cfg_valid, cfg_data, cfg_ready       cfg_valid and cfg_ready high
//
// A command occupies the engine from its transfer until its result cycle in
// S_DONE. Rejected commands, sign reads and unknown codes go there directly;
// bit reads pass S_FETCH_B, single-qubit gates S_FETCH_B and S_WRITE_B, and
// two-qubit gates S_FETCH_B, S_FETCH_A, S_WRITE_A and S_WRITE_B on the way.
// Reset restores the identity tableau at once through per-row valid bits.
// The result cannot be stalled; config writes are taken in any cycle.
`default_nettype none

module stabilizer_tableau_gate_engine_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [stge_pkg::CMD_W-1:0]     cmd,
  input  wire logic [stge_pkg::QUBIT_W-1:0]   qubit_a,
  input  wire logic [stge_pkg::QUBIT_W-1:0]   qubit_b,
  output logic                                done,
  output logic                                read_bit,
  output logic [stge_pkg::STATUS_W-1:0]       status,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [stge_pkg::COUNT_W-1:0]   cfg_data
);

  `include "stabilizer_tableau_gate_engine_unit_defines.svh"

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_FETCH_B = 6'b000010,
    S_FETCH_A = 6'b000100,
    S_WRITE_A = 6'b001000,
    S_WRITE_B = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  state_t                            state;
  state_t                            state_next;
  stge_pkg::cmd_t                    cmd_r;
  logic [stge_pkg::QUBIT_W-1:0]      qa_r;
  logic [stge_pkg::QUBIT_W-1:0]      qb_r;
  logic [stge_pkg::COUNT_W-1:0]      active_qubits;
  logic [stge_pkg::COUNT_W-1:0]      limit;
  logic [stge_pkg::MAX_QUBITS-1:0]   row_valid;
  stge_pkg::obs_vec_t                xobs_signs;
  stge_pkg::obs_vec_t                zobs_signs;
  stge_pkg::row_t                    row_a;
  stge_pkg::row_t                    row_b;
  stge_pkg::row_t                    fetched;
  stge_pkg::row_t                    unit_a;
  stge_pkg::row_t                    new_a;
  stge_pkg::row_t                    new_b;
  stge_pkg::half_t                   hx;
  stge_pkg::half_t                   hz;
  stge_pkg::status_t                 dec_status;
  stge_pkg::status_t                 status_r;
  logic                              dec_fetch;
  logic                              dec_bit;
  logic                              bit_r;
  logic                              a_bad;
  logic                              b_bad;
  logic                              two_qubit;
  logic                              accept;
  logic                              ram_we;
  logic                              ram_re;
  logic [stge_pkg::QUBIT_W-1:0]      ram_waddr;
  logic [stge_pkg::QUBIT_W-1:0]      ram_raddr;
  logic [stge_pkg::QUBIT_W-1:0]      fetch_addr;
  stge_pkg::row_t                    ram_wdata;
  logic [$bits(stge_pkg::row_t)-1:0] ram_rdata;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign done      = (state == S_DONE);
  assign read_bit  = bit_r;
  assign status    = status_r;

  assign limit = (active_qubits > stge_pkg::COUNT_W'(stge_pkg::MAX_QUBITS)) ?
                 stge_pkg::COUNT_W'(stge_pkg::MAX_QUBITS) : active_qubits;
  assign a_bad = ({1'b0, qubit_a} >= limit);
  assign b_bad = ({1'b0, qubit_b} >= limit);

  always_comb begin
    dec_status = stge_pkg::ST_OK;
    dec_fetch  = 1'b0;
    dec_bit    = 1'b0;
    unique case (stge_pkg::cmd_t'(cmd)) inside
      stge_pkg::CMD_CX, stge_pkg::CMD_CY, stge_pkg::CMD_CZ, stge_pkg::CMD_SWAP: begin
        if (a_bad || b_bad) begin
          dec_status = stge_pkg::ST_RANGE;
        end else if (qubit_a == qubit_b) begin
          dec_status = stge_pkg::ST_EQUAL;
        end else begin
          dec_fetch = 1'b1;
        end
      end
      stge_pkg::CMD_H, stge_pkg::CMD_H_XY, stge_pkg::CMD_H_YZ, stge_pkg::CMD_X: begin
        if (b_bad) begin
          dec_status = stge_pkg::ST_RANGE;
        end else begin
          dec_fetch = 1'b1;
        end
      end
      stge_pkg::CMD_RD_SIGN: begin
        if (a_bad) begin
          dec_status = stge_pkg::ST_RANGE;
        end else begin
          dec_bit = zobs_signs[qubit_a];
        end
      end
      stge_pkg::CMD_RD_ZX, stge_pkg::CMD_RD_XZ, stge_pkg::CMD_RD_ZZ: begin
        if (a_bad || b_bad) begin
          dec_status = stge_pkg::ST_RANGE;
        end else begin
          dec_fetch = 1'b1;
        end
      end
      default: begin
        dec_status = stge_pkg::ST_OK;
      end
    endcase
  end

  assign two_qubit = (cmd_r <= stge_pkg::CMD_SWAP);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = dec_fetch ? S_FETCH_B : S_DONE;
        end
      end
      S_FETCH_B: begin
        if (two_qubit) begin
          state_next = S_FETCH_A;
        end else if (cmd_r <= stge_pkg::CMD_X) begin
          state_next = S_WRITE_B;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FETCH_A: state_next = S_WRITE_A;
      S_WRITE_A: state_next = S_WRITE_B;
      S_WRITE_B: state_next = S_DONE;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  assign fetch_addr = (state == S_FETCH_B) ? qb_r : qa_r;
  assign fetched    = row_valid[fetch_addr] ? stge_pkg::row_t'(ram_rdata) :
                      stge_pkg::ident_row(fetch_addr);

  assign unit_a = two_qubit ? row_a : row_b;
  assign hx = stge_pkg::gate_half(cmd_r, unit_a.xx, unit_a.xz, row_b.xx, row_b.xz,
                                  xobs_signs);
  assign hz = stge_pkg::gate_half(cmd_r, unit_a.zx, unit_a.zz, row_b.zx, row_b.zz,
                                  zobs_signs);
  assign new_a = '{xx: hx.cx, xz: hx.cz, zx: hz.cx, zz: hz.cz};
  assign new_b = '{xx: hx.tx, xz: hx.tz, zx: hz.tx, zz: hz.tz};

  assign ram_re    = accept || (state == S_FETCH_B);
  assign ram_raddr = (state == S_IDLE) ? qubit_b : qa_r;
  assign ram_we    = (state == S_WRITE_A) || (state == S_WRITE_B);
  assign ram_waddr = (state == S_WRITE_A) ? qa_r : qb_r;
  assign ram_wdata = (state == S_WRITE_A) ? new_a : new_b;

  stge_ram #(
    .WIDTH ($bits(stge_pkg::row_t)),
    .DEPTH (stge_pkg::MAX_QUBITS)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      active_qubits <= stge_pkg::COUNT_W'(64);
      row_valid     <= '0;
      xobs_signs    <= '0;
      zobs_signs    <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        active_qubits <= cfg_data;
      end
      if (ram_we) begin
        row_valid[ram_waddr] <= 1'b1;
      end
      if (state == S_WRITE_B) begin
        xobs_signs <= hx.s;
        zobs_signs <= hz.s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= stge_pkg::cmd_t'(cmd);
      qa_r     <= qubit_a;
      qb_r     <= qubit_b;
      status_r <= dec_status;
      bit_r    <= dec_bit;
    end
    if (state == S_FETCH_B) begin
      row_b <= fetched;
      unique case (cmd_r) inside
        stge_pkg::CMD_RD_ZX: bit_r <= fetched.zx[qa_r];
        stge_pkg::CMD_RD_XZ: bit_r <= fetched.xz[qa_r];
        stge_pkg::CMD_RD_ZZ: bit_r <= fetched.zz[qa_r];
        default:             bit_r <= 1'b0;
      endcase
    end
    if (state == S_FETCH_A) begin
      row_a <= fetched;
    end
  end

  `STGE_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  `STGE_ASSERT_SAME(a_error_no_bit, clk, rst, done && (status != stge_pkg::ST_OK), !read_bit)
  `STGE_ASSERT_SAME(a_equal_two_qubit, clk, rst, done && (status == stge_pkg::ST_EQUAL), two_qubit)
  `STGE_ASSERT_SAME(a_write_distinct, clk, rst, state == S_WRITE_A, qa_r != qb_r)
  `STGE_ASSERT_NEXT(a_signs_hold, clk, rst, state != S_WRITE_B, $stable(xobs_signs) && $stable(zobs_signs))

endmodule

`default_nettype wire
